// ----- hdl/ntx_pkg.sv -----
// ntx_pkg: shared constants, codes and control structs for the nearest texel sampler.
// No dependencies; every file of the sampler uses it through scoped names.
`default_nettype none

package ntx_pkg;

  // texture limits and texel store geometry
  localparam int unsigned MAX_WIDTH    = 256;
  localparam int unsigned MAX_HEIGHT   = 256;
  localparam int unsigned MAX_CHANNELS = 4;
  localparam int unsigned STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
  localparam int unsigned STORE_AW     = $clog2(STORE_DEPTH);

  // four byte-wide banks so a texel's three bytes come out in one read
  localparam int unsigned BANKS        = 4;
  localparam int unsigned BANK_SEL_W   = $clog2(BANKS);
  localparam int unsigned BANK_AW      = STORE_AW - BANK_SEL_W;
  localparam int unsigned BANK_DEPTH   = STORE_DEPTH / BANKS;

  // field widths
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned COORD_W      = 32;
  localparam int unsigned FRAC_W       = 16;
  localparam int unsigned DIM_W        = $clog2(MAX_WIDTH + 1);
  localparam int unsigned IDX_W        = $clog2(MAX_WIDTH);
  localparam int unsigned PITCH_W      = $clog2(MAX_WIDTH * MAX_CHANNELS + 1);
  localparam int unsigned CH_W         = 3;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEX_WIDTH     = 2'd0,
    CFG_TEX_HEIGHT    = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  // load enables of the three index stages
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } stage_en_t;

  // texel store port control
  typedef struct packed {
    logic we;
    logic re;
  } store_ctl_t;

  // effective texture setup, already clamped to legal ranges
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             ch4;
  } tex_cfg_t;

endpackage

`default_nettype wire

// ----- hdl/ntx_bank.sv -----
// ntx_bank: one byte-wide bank of the texel store, one write and one registered read port.
// Depends on ntx_pkg for the bank depth.
`default_nettype none

module ntx_bank (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ntx_pkg::BANK_AW-1:0] waddr_i,
  input  logic [ntx_pkg::BYTE_W-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [ntx_pkg::BANK_AW-1:0] raddr_i,
  output logic [ntx_pkg::BYTE_W-1:0]  rdata_o
);

  logic [ntx_pkg::BYTE_W-1:0] mem [ntx_pkg::BANK_DEPTH];
  logic [ntx_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/ntx_store.sv -----
// ntx_store: banked texel store; writes one byte, reads three consecutive bytes per sample.
// Depends on ntx_pkg and ntx_bank.
`default_nettype none

module ntx_store (
  input  logic                         clk_i,
  input  ntx_pkg::store_ctl_t          ctl_i,
  input  logic [ntx_pkg::STORE_AW-1:0] addr_i,
  input  logic [ntx_pkg::BYTE_W-1:0]   wdata_i,
  output logic [ntx_pkg::BYTE_W-1:0]   red_o,
  output logic [ntx_pkg::BYTE_W-1:0]   green_o,
  output logic [ntx_pkg::BYTE_W-1:0]   blue_o
);

  logic [ntx_pkg::BANKS-1:0][ntx_pkg::BYTE_W-1:0] rdata;
  logic [ntx_pkg::BANK_SEL_W-1:0]                 off0_q;
  logic [ntx_pkg::BANK_SEL_W-1:0]                 off1;
  logic [ntx_pkg::BANK_SEL_W-1:0]                 off2;

  for (genvar b = 0; b < ntx_pkg::BANKS; b++) begin : g_bank
    logic [ntx_pkg::BANK_SEL_W-1:0] skew;
    logic [ntx_pkg::STORE_AW-1:0]   raddr_full;
    logic                           we;

    // bank b holds byte addr+skew; the sum wraps at the top of the store
    assign skew       = ntx_pkg::BANK_SEL_W'(b) - addr_i[ntx_pkg::BANK_SEL_W-1:0];
    assign raddr_full = addr_i
                      + {(ntx_pkg::STORE_AW - ntx_pkg::BANK_SEL_W)'(0), skew};
    assign we         = ctl_i.we
                      && (addr_i[ntx_pkg::BANK_SEL_W-1:0] == ntx_pkg::BANK_SEL_W'(b));

    ntx_bank u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (addr_i[ntx_pkg::STORE_AW-1:ntx_pkg::BANK_SEL_W]),
      .wdata_i (wdata_i),
      .re_i    (ctl_i.re),
      .raddr_i (raddr_full[ntx_pkg::STORE_AW-1:ntx_pkg::BANK_SEL_W]),
      .rdata_o (rdata[b])
    );
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      off0_q <= addr_i[ntx_pkg::BANK_SEL_W-1:0];
    end
  end

  assign off1    = off0_q + ntx_pkg::BANK_SEL_W'(1);
  assign off2    = off0_q + ntx_pkg::BANK_SEL_W'(2);
  assign red_o   = rdata[off0_q];
  assign green_o = rdata[off1];
  assign blue_o  = rdata[off2];

endmodule

`default_nettype wire

// ----- hdl/ntx_index.sv -----
// ntx_index: three-stage texel index path: wrap coordinates, pick column and row,
// form the byte address. Depends on ntx_pkg.
`default_nettype none

module ntx_index (
  input  logic                                clk_i,
  input  ntx_pkg::stage_en_t                  en_i,
  input  ntx_pkg::tex_cfg_t                   cfg_i,
  input  ntx_pkg::action_e                    action_i,
  input  logic [ntx_pkg::STORE_AW-1:0]        byte_address_i,
  input  logic [ntx_pkg::BYTE_W-1:0]          byte_value_i,
  input  logic signed [ntx_pkg::COORD_W-1:0]  coord_u_i,
  input  logic signed [ntx_pkg::COORD_W-1:0]  coord_v_i,
  output ntx_pkg::action_e                    action_o,
  output logic [ntx_pkg::STORE_AW-1:0]        addr_o,
  output logic [ntx_pkg::BYTE_W-1:0]          value_o
);

  localparam int unsigned FW = ntx_pkg::FRAC_W;
  localparam int unsigned DW = ntx_pkg::DIM_W;
  localparam int unsigned IW = ntx_pkg::IDX_W;
  localparam int unsigned PW = ntx_pkg::PITCH_W;
  localparam int unsigned AW = ntx_pkg::STORE_AW;
  localparam logic [FW:0] ONE_Q = {1'b1, FW'(0)};

  // stage 1: sign and fraction magnitude
  ntx_pkg::action_e            act1_q;
  logic [AW-1:0]               baddr1_q;
  logic [ntx_pkg::BYTE_W-1:0]  bval1_q;
  logic                        neg_u1_q, neg_v1_q;
  logic [FW-1:0]               mag_u1_q, mag_v1_q;
  logic [FW-1:0]               mag_u, mag_v;

  // stage 2: column and row
  ntx_pkg::action_e            act2_q;
  logic [AW-1:0]               baddr2_q;
  logic [ntx_pkg::BYTE_W-1:0]  bval2_q;
  logic [IW-1:0]               col2_q, row2_q;
  logic [FW+DW-1:0]            prod_u;
  logic [FW:0]                 t_v;
  logic [FW+DW:0]              prod_v;
  logic [DW-1:0]               col_raw, col_sat, wm1, hm1, row_sat;
  logic [DW:0]                 row_raw;

  // stage 3: byte address
  ntx_pkg::action_e            act3_q;
  logic [AW-1:0]               addr3_q;
  logic [ntx_pkg::BYTE_W-1:0]  bval3_q;
  logic [PW-1:0]               pitch;
  logic [PW+IW-1:0]            row_off, lin;
  logic [IW+1:0]               col_off;

  // fmod-style wrap: fraction keeps the coordinate's sign
  assign mag_u = coord_u_i[ntx_pkg::COORD_W-1] ? (~coord_u_i[FW-1:0] + FW'(1))
                                               : coord_u_i[FW-1:0];
  assign mag_v = coord_v_i[ntx_pkg::COORD_W-1] ? (~coord_v_i[FW-1:0] + FW'(1))
                                               : coord_v_i[FW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i.en1) begin
      act1_q   <= action_i;
      baddr1_q <= byte_address_i;
      bval1_q  <= byte_value_i;
      neg_u1_q <= coord_u_i[ntx_pkg::COORD_W-1];
      neg_v1_q <= coord_v_i[ntx_pkg::COORD_W-1];
      mag_u1_q <= mag_u;
      mag_v1_q <= mag_v;
    end
  end

  assign wm1     = cfg_i.width - DW'(1);
  assign hm1     = cfg_i.height - DW'(1);
  assign prod_u  = {DW'(0), mag_u1_q} * {FW'(0), cfg_i.width};
  assign col_raw = prod_u[FW +: DW];
  // negative u lands on column 0
  assign col_sat = neg_u1_q         ? DW'(0) :
                   (col_raw > wm1)  ? wm1    : col_raw;

  assign t_v     = ONE_Q - {1'b0, mag_v1_q};
  assign prod_v  = {DW'(0), t_v} * {(FW + 1)'(0), cfg_i.height};
  assign row_raw = prod_v[FW +: DW + 1];
  // negative v: 1 - frac exceeds 1, row pins at the bottom
  assign row_sat = (neg_v1_q || (row_raw > {1'b0, hm1})) ? hm1 : row_raw[DW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i.en2) begin
      act2_q   <= act1_q;
      baddr2_q <= baddr1_q;
      bval2_q  <= bval1_q;
      col2_q   <= col_sat[IW-1:0];
      row2_q   <= row_sat[IW-1:0];
    end
  end

  assign pitch   = cfg_i.ch4 ? {cfg_i.width, 2'b00}
                             : ({1'b0, cfg_i.width, 1'b0} + {2'b00, cfg_i.width});
  assign row_off = {IW'(0), pitch} * {PW'(0), row2_q};
  assign col_off = cfg_i.ch4 ? {col2_q, 2'b00}
                             : ({1'b0, col2_q, 1'b0} + {2'b00, col2_q});
  assign lin     = row_off + {(PW - 2)'(0), col_off};

  always_ff @(posedge clk_i) begin
    if (en_i.en3) begin
      act3_q  <= act2_q;
      bval3_q <= bval2_q;
      addr3_q <= (act2_q == ntx_pkg::ACT_SAMPLE) ? lin[AW-1:0] : baddr2_q;
    end
  end

  assign action_o = act3_q;
  assign addr_o   = addr3_q;
  assign value_o  = bval3_q;

endmodule

`default_nettype wire

// ----- hdl/nearest_texel_sampler.sv -----
// nearest_texel_sampler: top level of the nearest-neighbor texel sampler.
// Depends on ntx_pkg, ntx_index, ntx_store (and ntx_bank below it).
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | action, byte_address, byte_value, u, v
//  out     | source    | out_valid_o / out_stall_i| red, green, blue
//  cfg     | sink      | cfg_valid_i / cfg_ready_o| cfg_index (0 width, 1 height, 2 channels)
//
// One input word per cycle, sustained while the output is not stalled. A sample's word is
// valid on the output once it has passed stage 1, stages 2 and 3, the store read register
// and the output register; a write word updates the store as it leaves stage 3 and
// produces nothing.
// Reset clears the pipeline valids and the texture setup only; the texel store is not
// cleared and holds garbage until written, so no clearing pass runs after reset.
// Each stage advances when it is empty or its successor moves, so bubbles squeeze out
// and the input keeps flowing while a finished word waits on a stalled output, until every stage is full.
`default_nettype none

module nearest_texel_sampler (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 action_i,
  input  logic [ntx_pkg::STORE_AW-1:0]         byte_address_i,
  input  logic [ntx_pkg::BYTE_W-1:0]           byte_value_i,
  input  logic signed [ntx_pkg::COORD_W-1:0]   coord_u_i,
  input  logic signed [ntx_pkg::COORD_W-1:0]   coord_v_i,

  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ntx_pkg::BYTE_W-1:0]           red_o,
  output logic [ntx_pkg::BYTE_W-1:0]           green_o,
  output logic [ntx_pkg::BYTE_W-1:0]           blue_o,

  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ntx_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ntx_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned DW = ntx_pkg::DIM_W;

  // ---------------------------------------------------------------------------
  // Texture setup. Values are clamped on the way in so the datapath only ever
  // sees legal sizes: zero becomes one, oversize pins at the maximum.
  // ---------------------------------------------------------------------------
  ntx_pkg::tex_cfg_t cfg_q;

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] d,
                                              input logic [DW-1:0] lim);
    logic [DW-1:0] r;
    if (d == DW'(0)) begin
      r = DW'(1);
    end else if (d > lim) begin
      r = lim;
    end else begin
      r = d;
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= DW'(1);
      cfg_q.height <= DW'(1);
      cfg_q.ch4    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (ntx_pkg::cfg_idx_e'(cfg_index_i))
        ntx_pkg::CFG_TEX_WIDTH: begin
          cfg_q.width <= clamp_dim(cfg_data_i[DW-1:0], DW'(ntx_pkg::MAX_WIDTH));
        end
        ntx_pkg::CFG_TEX_HEIGHT: begin
          cfg_q.height <= clamp_dim(cfg_data_i[DW-1:0], DW'(ntx_pkg::MAX_HEIGHT));
        end
        ntx_pkg::CFG_CHANNEL_COUNT: begin
          // only the low three bits count; 4 and up means four bytes per texel
          cfg_q.ch4 <= (cfg_data_i[ntx_pkg::CH_W-1:0] >= ntx_pkg::CH_W'(ntx_pkg::MAX_CHANNELS));
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. vld1..vld3 track the index stages, vld4 the store read
  // register (samples only), out_valid_q the output register.
  // ---------------------------------------------------------------------------
  logic vld1_q, vld2_q, vld3_q, vld4_q, out_valid_q;
  logic free1, free2, free3, free4, free5;

  ntx_pkg::stage_en_t  stage_en;
  ntx_pkg::store_ctl_t store_ctl;
  ntx_pkg::action_e    act3;

  assign free5 = !out_valid_q || !out_stall_i;
  assign free4 = !vld4_q || free5;
  assign free3 = !vld3_q || free4;
  assign free2 = !vld2_q || free3;
  assign free1 = !vld1_q || free2;

  assign in_stall_o   = !free1;
  assign stage_en.en1 = free1;
  assign stage_en.en2 = free2;
  assign stage_en.en3 = free3;

  // writes commit as they leave stage 3, so they stay in order with sample reads
  assign store_ctl.we = free4 && vld3_q && (act3 == ntx_pkg::ACT_WRITE);
  assign store_ctl.re = free4 && vld3_q && (act3 == ntx_pkg::ACT_SAMPLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q      <= 1'b0;
      vld2_q      <= 1'b0;
      vld3_q      <= 1'b0;
      vld4_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (free1) vld1_q <= in_valid_i;
      if (free2) vld2_q <= vld1_q;
      if (free3) vld3_q <= vld2_q;
      if (free4) vld4_q <= store_ctl.re;
      if (free5) out_valid_q <= vld4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  logic [ntx_pkg::STORE_AW-1:0] addr3;
  logic [ntx_pkg::BYTE_W-1:0]   value3;
  logic [ntx_pkg::BYTE_W-1:0]   st_red, st_green, st_blue;
  logic [ntx_pkg::BYTE_W-1:0]   red_q, green_q, blue_q;

  ntx_index u_index (
    .clk_i          (clk_i),
    .en_i           (stage_en),
    .cfg_i          (cfg_q),
    .action_i       (ntx_pkg::action_e'(action_i)),
    .byte_address_i (byte_address_i),
    .byte_value_i   (byte_value_i),
    .coord_u_i      (coord_u_i),
    .coord_v_i      (coord_v_i),
    .action_o       (act3),
    .addr_o         (addr3),
    .value_o        (value3)
  );

  ntx_store u_store (
    .clk_i   (clk_i),
    .ctl_i   (store_ctl),
    .addr_i  (addr3),
    .wdata_i (value3),
    .red_o   (st_red),
    .green_o (st_green),
    .blue_o  (st_blue)
  );

  // output register: holds the word while the consumer stalls
  always_ff @(posedge clk_i) begin
    if (free5) begin
      red_q   <= st_red;
      green_q <= st_green;
      blue_q  <= st_blue;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (vld1_q && vld2_q && vld3_q && vld4_q && out_valid_q))
    else $error("input stalled with a bubble in the pipeline");

  a_read_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_ctl.re |=> vld4_q)
    else $error("store read did not mark the read stage valid");

  a_store_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(store_ctl.we && store_ctl.re))
    else $error("store written and read in the same cycle");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for nearest_texel_sampler. It holds a texel scoreboard class that
// mirrors the texel store and texture setup, and tasks that drive words and register writes.
// Depends on ntx_pkg and the sampler RTL only.
`default_nettype none

module tb;

  localparam longint      STORE_BYTES    = ntx_pkg::STORE_DEPTH;
  localparam int unsigned SETTLE_CYCLES  = 12;    // writes make no result; let them land
  localparam int unsigned TAIL_CYCLES    = 20;    // idle margin after the last result before finishing
  localparam int unsigned HOLD_CYCLES    = 80;    // long output hold-off, fills the pipe
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int unsigned PHASE_WORDS    = 70;
  localparam int unsigned PHASES         = 8;
  // register index the block does not decode; a write to it must change nothing
  localparam logic [ntx_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } texel_t;

  // Scoreboard: shadow texel store, shadow setup registers, and the queue of texels
  // that accepted sample words still owe us.
  class texel_scoreboard;
    logic [7:0] store [ntx_pkg::STORE_DEPTH];
    bit         written [ntx_pkg::STORE_DEPTH];
    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic [2:0] chan_reg;
    texel_t     owed_q [$];
    int         errors;

    function new();
      width_reg  = 9'd1;
      height_reg = 9'd1;
      chan_reg   = 3'd3;
      errors     = 0;
    endfunction

    function void set_reg(logic [ntx_pkg::CFG_IDX_W-1:0] idx, logic [8:0] data);
      case (idx)
        ntx_pkg::CFG_TEX_WIDTH:     width_reg  = data;
        ntx_pkg::CFG_TEX_HEIGHT:    height_reg = data;
        ntx_pkg::CFG_CHANNEL_COUNT: chan_reg   = data[2:0];
        default: ;
      endcase
    endfunction

    // setup as the block uses it: zero reads as one, oversize saturates
    function void live_setup(output longint w, output longint h, output longint ch);
      w  = width_reg;
      h  = height_reg;
      ch = chan_reg;
      if (w < 1) w = 1;
      if (w > longint'(ntx_pkg::MAX_WIDTH)) w = ntx_pkg::MAX_WIDTH;
      if (h < 1) h = 1;
      if (h > longint'(ntx_pkg::MAX_HEIGHT)) h = ntx_pkg::MAX_HEIGHT;
      if (ch < 3) ch = 3;
      if (ch > longint'(ntx_pkg::MAX_CHANNELS)) ch = ntx_pkg::MAX_CHANNELS;
    endfunction

    function longint region_bytes();
      longint w, h, ch;
      live_setup(w, h, ch);
      return w * h * ch;
    endfunction

    // fmod-style wrap of Q15.16: integer part cut toward zero, fraction keeps the sign
    function longint wrap_frac(logic [31:0] c);
      longint x;
      x = longint'($signed(c));
      if (x >= 0) return x & 64'hFFFF;
      return -((-x) & 64'hFFFF);
    endfunction

    // byte address of the first byte of the texel picked for (u, v)
    function longint texel_offset(logic [31:0] u, logic [31:0] v);
      longint w, h, ch, fu, fv, pu, col, row;
      live_setup(w, h, ch);
      fu  = wrap_frac(u);
      fv  = wrap_frac(v);
      pu  = fu * w;
      col = (pu > 0) ? (pu >>> 16) : 0;
      if (col > w - 1) col = w - 1;
      row = ((65536 - fv) * h) >>> 16;   // row flipped; never negative
      if (row > h - 1) row = h - 1;
      return (ch * w * row + col * ch) % STORE_BYTES;
    endfunction

    function bool_written(longint a);
      return written[a % STORE_BYTES];
    endfunction

    function void note_word(ntx_pkg::action_e act, logic [ntx_pkg::STORE_AW-1:0] addr,
                            logic [7:0] val, logic [31:0] u, logic [31:0] v);
      longint base;
      texel_t t;
      if (act == ntx_pkg::ACT_WRITE) begin
        store[addr]   = val;
        written[addr] = 1'b1;
      end else begin
        base    = texel_offset(u, v);
        t.red   = store[base];
        t.green = store[(base + 1) % STORE_BYTES];
        t.blue  = store[(base + 2) % STORE_BYTES];
        owed_q.push_back(t);
      end
    endfunction

    function void check_texel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      texel_t want;
      if (owed_q.size() == 0) begin
        $error("texel word with nothing owed: red=%0h green=%0h blue=%0h", r, g, b);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (r !== want.red) begin
        $error("red mismatch: expected %0h, actual %0h", want.red, r);
        errors++;
      end
      if (g !== want.green) begin
        $error("green mismatch: expected %0h, actual %0h", want.green, g);
        errors++;
      end
      if (b !== want.blue) begin
        $error("blue mismatch: expected %0h, actual %0h", want.blue, b);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------------
  // clock, reset, DUT
  // ---------------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                                in_valid_i     = 1'b0;
  logic                                in_stall_o;
  logic                                action_i       = 1'b0;
  logic [ntx_pkg::STORE_AW-1:0]        byte_address_i = '0;
  logic [ntx_pkg::BYTE_W-1:0]          byte_value_i   = '0;
  logic signed [ntx_pkg::COORD_W-1:0]  coord_u_i      = '0;
  logic signed [ntx_pkg::COORD_W-1:0]  coord_v_i      = '0;

  logic                                out_valid_o;
  logic                                out_stall_i    = 1'b0;
  logic [ntx_pkg::BYTE_W-1:0]          red_o;
  logic [ntx_pkg::BYTE_W-1:0]          green_o;
  logic [ntx_pkg::BYTE_W-1:0]          blue_o;

  logic                                cfg_valid_i    = 1'b0;
  logic                                cfg_ready_o;
  logic [ntx_pkg::CFG_IDX_W-1:0]       cfg_index_i    = '0;
  logic [ntx_pkg::CFG_DATA_W-1:0]      cfg_data_i     = '0;

  always #1 clk_i = ~clk_i;

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  nearest_texel_sampler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .byte_address_i (byte_address_i),
    .byte_value_i   (byte_value_i),
    .coord_u_i      (coord_u_i),
    .coord_v_i      (coord_v_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  texel_scoreboard sb;

  // knobs shared by the sender and the receiver; zero means no idling on that side
  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;
  bit          hold_req   = 1'b0;  // raised by the stimulus, cleared by the receiver
  int unsigned words_sent = 0;

  // ---------------------------------------------------------------------------------
  // result side: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------------
  initial begin : texel_sink
    int unsigned n;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        n = $urandom_range(1, 6);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // results are taken at the rising edge: valid high, our stall low
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_texel(red_o, green_o, blue_o);
  end

  // watchdog: any handshake on any channel resets the quiet count
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("nearest_texel_sampler test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------------

  // Offer one word; payload changes only at the falling edge and holds while stalled.
  task automatic send_word(ntx_pkg::action_e act, logic [ntx_pkg::STORE_AW-1:0] addr,
                           logic [7:0] val, logic [31:0] u, logic [31:0] v);
    int unsigned gap;
    @(negedge clk_i);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    byte_address_i <= addr;
    byte_value_i   <= val;
    coord_u_i      <= u;
    coord_v_i      <= v;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(act, addr, val, u, v);
    words_sent++;
  endtask

  task automatic park_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // sender pauses until every owed texel is back
  task automatic drain_results();
    park_input();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ntx_pkg::CFG_IDX_W-1:0] idx, logic [8:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // setup changes only with the pipe empty; trailing store writes get SETTLE_CYCLES to land
  task automatic set_texture(logic [8:0] w, logic [8:0] h, logic [8:0] ch);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(ntx_pkg::CFG_TEX_WIDTH, w);
    write_reg(ntx_pkg::CFG_TEX_HEIGHT, h);
    write_reg(ntx_pkg::CFG_CHANNEL_COUNT, ch);
  endtask

  // Sample at (u, v). Any byte of the target texel not yet written gets a random byte
  // first, so the block never reads an undefined store location.
  task automatic sample_at(logic [31:0] u, logic [31:0] v);
    longint base, a;
    int k;
    base = sb.texel_offset(u, v);
    for (k = 0; k < 3; k++) begin
      a = (base + k) % STORE_BYTES;
      if (!sb.bool_written(a))
        send_word(ntx_pkg::ACT_WRITE, 18'(a), 8'($urandom), $urandom, $urandom);
    end
    send_word(ntx_pkg::ACT_SAMPLE, 18'($urandom), 8'($urandom), u, v);
  endtask

  // coordinate mix: wide random, near the unit range, whole numbers, and edge values
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      2: return $urandom << 16;
      3: begin
        case ($urandom_range(0, 6))
          0: return 32'h0000_0000;
          1: return 32'h0000_FFFF;
          2: return 32'h7FFF_FFFF;
          3: return 32'h8000_0000;
          4: return 32'hFFFF_FFFF;
          5: return 32'hFFFF_0001;
          default: return 32'h0000_8000;
        endcase
      end
      default: return $urandom_range(0, 32'hFFFF);
    endcase
  endfunction

  // mostly samples; some writes retouch the live texture, a few land anywhere
  task automatic random_word();
    int unsigned r;
    longint span;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      send_word(ntx_pkg::ACT_WRITE, 18'($urandom), 8'($urandom), $urandom, $urandom);
    end else if (r < 20) begin
      span = sb.region_bytes();
      send_word(ntx_pkg::ACT_WRITE, 18'($urandom_range(0, 32'(span - 1))), 8'($urandom),
                $urandom, $urandom);
    end else begin
      sample_at(rand_coord(), rand_coord());
    end
  endtask

  // ---------------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------------
  initial begin : stimulus
    logic [8:0] w, h, ch;
    int unsigned p, start;
    bit held, paused;
    sb = new();
    held   = 1'b0;
    paused = 1'b0;
    @(posedge rst_ni);

    // Directed, under the reset setup (1x1, 3 bytes): every coordinate hits texel 0.
    send_word(ntx_pkg::ACT_WRITE, 18'd0, 8'h00, 32'h0, 32'h0);
    send_word(ntx_pkg::ACT_WRITE, 18'd1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ntx_pkg::ACT_WRITE, 18'd2, 8'hA5, 32'h0, 32'h0);
    send_word(ntx_pkg::ACT_WRITE, 18'h3FFFF, 8'h5A, 32'h0, 32'h0);  // top of the store
    sample_at(32'h0000_0000, 32'h0000_0000);
    sample_at(32'h7FFF_FFFF, 32'h8000_0000);
    sample_at(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    sample_at(32'h0000_FFFF, 32'h0001_0000);
    send_word(ntx_pkg::ACT_WRITE, 18'd1, 8'h3C, 32'h0, 32'h0);      // overwrite, then reread
    sample_at(32'h0000_0000, 32'h0000_0000);

    // Directed on a 4x4, 4-byte texture: corners, negative fractions (column 0 and
    // bottom row), zero fraction (row saturates), most negative coordinate.
    set_texture(9'd4, 9'd4, 9'd4);
    sample_at(32'h0000_0000, 32'h0000_0000);
    sample_at(32'h0000_FFFF, 32'h0000_FFFF);
    sample_at(32'hFFFF_8000, 32'hFFFF_8000);
    sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    sample_at(32'h8000_0000, 32'h8000_0000);

    // Random phases, each with its own texture setup.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin w = 9'd511; h = 9'd511; ch = 9'd7; end  // saturates to the maximum
        1: begin w = 9'd0;   h = 9'd0;   ch = 9'd0; end  // zeros read as the minimum
        3: begin w = 9'd256; h = 9'd1;   ch = 9'd2; end
        4: begin w = 9'd1;   h = 9'd256; ch = 9'd5; end
        5: begin
          w  = 9'($urandom_range(0, 511));
          h  = 9'($urandom_range(0, 511));
          ch = 9'($urandom_range(0, 7));
        end
        default: begin
          w  = 9'($urandom_range(1, 12));
          h  = 9'($urandom_range(1, 12));
          ch = 9'($urandom_range(3, 4));
        end
      endcase
      set_texture(w, h, ch);
      if (p == 1)
        write_reg(CFG_SPARE_IDX, 9'($urandom));

      // no idling on phase 3 and on the closing phase
      gap_pct   = (p == 3 || p == PHASES - 1) ? 0 : 25;
      stall_pct = (p == 3 || p == PHASES - 1) ? 0 : 25;

      start = words_sent;
      while (words_sent - start < PHASE_WORDS) begin
        // long output hold-off while we keep pushing; the pipe fills and stalls us
        if (p == 2 && !held && words_sent - start >= 10) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
        // sender waits for the pipe to run dry mid-phase
        if (p == 4 && !paused && words_sent - start >= 30) begin
          drain_results();
          paused = 1'b1;
        end
        random_word();
      end
    end

    park_input();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.errors == 0)
      $display("nearest_texel_sampler test passed");
    else
      $display("nearest_texel_sampler test failed");
    $finish;
  end

endmodule

`default_nettype wire
